[src/ntt_pkg.sv]
// Shared types and constants for the number theoretic transform core.
// Used by the top level, the modular multiplier and nothing else; no dependencies.
package ntt_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int DATA_W     = 30;

  localparam logic [3:0]        MAX_LOG  = 4'(ADDR_W);
  localparam logic [DATA_W-1:0] MODP     = 30'd998244353;
  localparam logic [DATA_W-1:0] ROOT_FWD = 30'd3;
  localparam logic [DATA_W-1:0] ROOT_INV = 30'd332748118;

  // Register indexes of the configuration port
  localparam logic CFG_LOG_LENGTH   = 1'b0;
  localparam logic CFG_INVERSE_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RESP,
    ST_BR_CHECK,
    ST_BR_RD_B,
    ST_BR_WR_A,
    ST_BR_WR_B,
    ST_STAGE,
    ST_PW_TEST,
    ST_PW_ACC,
    ST_PW_SQ,
    ST_BF_RD_A,
    ST_BF_RD_B,
    ST_BF_MUL,
    ST_BF_MWAIT,
    ST_BF_WR_A,
    ST_BF_WR_B,
    ST_BF_WWAIT,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_MWAIT,
    ST_SC_WR
  } state_t;

  // Request to the modular multiplier
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mm_req_t;

endpackage

[src/ntt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ntt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ntt_modmul.sv]
// Pipelined Barrett modular multiplier a*b mod p; the product passes through the operand,
// product, quotient, quotient-times-p, remainder and result registers (done pulses with it). Depends on ntt_pkg.
module ntt_modmul (
  input  logic                       clk,
  input  logic                       rst,
  input  ntt_pkg::mm_req_t           req,
  output logic [ntt_pkg::DATA_W-1:0] result,
  output logic                       done
);
  import ntt_pkg::*;

  localparam logic [63:0] MU_WIDE = (64'd1 << (2 * DATA_W)) / {34'd0, MODP};
  localparam logic [30:0] MU      = MU_WIDE[30:0];
  localparam logic [31:0] P1      = {2'b00, MODP};
  localparam logic [31:0] P2      = {1'b0, MODP, 1'b0};

  logic [4:0]        vld;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [59:0]       prod;
  logic [61:0]       q2;
  logic [31:0]       qp;
  logic [31:0]       lo1;
  logic [31:0]       lo2;
  logic [31:0]       r;
  logic [31:0]       r_red;

  // Fold the Barrett remainder, below 3p, into the range of p
  always_comb begin
    if (r >= P2) begin
      r_red = r - P2;
    end else if (r >= P1) begin
      r_red = r - P1;
    end else begin
      r_red = r;
    end
  end

  // Advance the valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[3:0], req.start};
      done <= vld[4];
    end
  end

  // Operands, product, quotient estimate, remainder, fold
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end
    prod <= {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    q2   <= {31'd0, prod[59:29]} * {31'd0, MU};
    lo1  <= prod[31:0];
    qp   <= {1'b0, q2[61:31]} * P1;
    lo2  <= lo1;
    r    <= lo2 - qp;
    if (vld[4]) begin
      result <= r_red[DATA_W-1:0];
    end
  end

endmodule

[src/number_theoretic_transform_core.sv]
// Radix-2 number theoretic transform modulo 998244353 over a 1024-word memory.
// Depends on ntt_pkg, ntt_ram and ntt_modmul.
//
// Each input transfer loads a coefficient (reduced mod p), reads one back, runs a
// transform over the first 2^log_length words or does nothing; every transfer gives one result.
// A load passes through the response state, an in-range read through a read-wait
// state and the response state before the next input transfer, longer while the
// output is stalled. A transform works out of the single coefficient RAM (one read
// and one write port) with one pipelined modular multiplier: the bit-reversal pass
// checks every index and swaps each word with its reversed partner, each stage
// first raises the root to its power (up to 35 multiplies), and each butterfly
// costs two multiplies, two RAM reads and two RAM writes; an inverse transform
// ends with a length-scaling pass. New input is taken only while idle.
module number_theoretic_transform_core (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata: index[9:0], value[39:10]
  input  logic [39:0] s_axis_tdata,
  // s_axis_tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // m_axis_tdata: read_value[29:0], zero[31:30]
  output logic [31:0] m_axis_tdata,
  // m_axis_tuser: status[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import ntt_pkg::*;

  localparam int CNT_W = ADDR_W + 1;

  // Configuration
  logic [3:0] log_length;
  logic       inverse_mode;

  // Control
  state_t state;
  state_t state_next;

  // Datapath registers
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] y;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] step;
  logic [DATA_W-1:0] scale;
  logic [DATA_W-1:0] pacc;
  logic [DATA_W-1:0] pbase;
  logic [DATA_W-1:0] pexp;
  logic              pow_scale;
  logic [3:0]        stage;
  logic [CNT_W-1:0]  bi;
  logic [CNT_W-1:0]  bj;
  logic [DATA_W-1:0] rv;
  logic              st;
  logic [DATA_W-1:0] out_value;

  // Memory and multiplier
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  mm_req_t           mm_req;
  logic [DATA_W-1:0] mm_result;
  logic              mm_done;

  // Derived values
  logic [3:0]        lsat;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  k;
  logic [ADDR_W-1:0] in_index;
  logic [DATA_W-1:0] in_value;
  logic [DATA_W-1:0] in_value_red;
  logic              in_range;
  logic              in_xfer;
  logic [ADDR_W-1:0] rev;
  logic [ADDR_W-1:0] rev_full;
  logic [CNT_W-1:0]  addr_a;
  logic [CNT_W-1:0]  addr_b;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_red;
  logic [DATA_W-1:0] diff;
  logic              out_free;

  ntt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ntt_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .req    (mm_req),
    .result (mm_result),
    .done   (mm_done)
  );

  // Saturate the length and derive addresses
  assign lsat         = (log_length > MAX_LOG) ? MAX_LOG : log_length;
  assign n            = CNT_W'(1) << lsat;
  assign k            = CNT_W'(1) << stage;
  assign in_index     = s_axis_tdata[ADDR_W-1:0];
  assign in_value     = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign in_value_red = (in_value >= MODP) ? in_value - MODP : in_value;
  assign in_range     = {1'b0, in_index} < n;
  assign in_xfer      = s_axis_tvalid && s_axis_tready;
  assign addr_a       = bj + bi;
  assign addr_b       = bj + bi + k;
  assign sum          = {1'b0, x} + {1'b0, y};
  assign sum_red      = (sum >= {1'b0, MODP}) ? DATA_W'(sum - {1'b0, MODP})
                                              : sum[DATA_W-1:0];
  assign diff         = (x >= y) ? x - y : x + (MODP - y);
  assign out_free     = !m_axis_tvalid || m_axis_tready;

  // Bit-reverse the counter over the active width
  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      rev_full[b] = bi[ADDR_W-1-b];
    end
    rev = rev_full >> (MAX_LOG - lsat);
  end

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tdata  = {2'b00, out_value};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      log_length   <= MAX_LOG;
      inverse_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LOG_LENGTH:   log_length   <= cfg_wdata;
        CFG_INVERSE_MODE: inverse_mode <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM and multiplier controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = addr_a[ADDR_W-1:0];
    ram_wdata  = sum_red;
    ram_raddr  = addr_a[ADDR_W-1:0];
    mm_req     = '0;
    unique case (state)
      ST_IDLE: begin
        ram_waddr = in_index;
        ram_wdata = in_value_red;
        ram_raddr = in_index;
        if (in_xfer) begin
          unique case (op_t'(s_axis_tuser))
            OP_LOAD: begin
              ram_we     = in_range;
              state_next = ST_RESP;
            end
            OP_READ: state_next = in_range ? ST_RD_WAIT : ST_RESP;
            OP_RUN:  state_next = ST_BR_CHECK;
            OP_NONE: state_next = ST_RESP;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BR_CHECK: begin
        ram_raddr = bi[ADDR_W-1:0];
        if (bi == n) begin
          state_next = ST_STAGE;
        end else if (bi[ADDR_W-1:0] < rev) begin
          state_next = ST_BR_RD_B;
        end
      end
      ST_BR_RD_B: begin
        ram_raddr  = rev;
        state_next = ST_BR_WR_A;
      end
      ST_BR_WR_A: begin
        ram_we     = 1'b1;
        ram_waddr  = bi[ADDR_W-1:0];
        ram_wdata  = ram_rdata;
        state_next = ST_BR_WR_B;
      end
      ST_BR_WR_B: begin
        ram_we     = 1'b1;
        ram_waddr  = rev;
        ram_wdata  = x;
        state_next = ST_BR_CHECK;
      end
      ST_STAGE: begin
        if ({1'b0, stage} != {1'b0, lsat}) begin
          state_next = ST_PW_TEST;
        end else if (inverse_mode) begin
          state_next = ST_PW_TEST;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_PW_TEST: begin
        if (pexp == '0) begin
          state_next = pow_scale ? ST_SC_RD : ST_BF_RD_A;
        end else if (pexp[0]) begin
          mm_req     = '{start: 1'b1, a: pacc, b: pbase};
          state_next = ST_PW_ACC;
        end else begin
          mm_req     = '{start: 1'b1, a: pbase, b: pbase};
          state_next = ST_PW_SQ;
        end
      end
      ST_PW_ACC: begin
        if (mm_done) begin
          mm_req     = '{start: 1'b1, a: pbase, b: pbase};
          state_next = ST_PW_SQ;
        end
      end
      ST_PW_SQ: begin
        if (mm_done) begin
          state_next = ST_PW_TEST;
        end
      end
      ST_BF_RD_A: state_next = ST_BF_RD_B;
      ST_BF_RD_B: begin
        ram_raddr  = addr_b[ADDR_W-1:0];
        state_next = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        mm_req     = '{start: 1'b1, a: w, b: ram_rdata};
        state_next = ST_BF_MWAIT;
      end
      ST_BF_MWAIT: begin
        if (mm_done) begin
          state_next = ST_BF_WR_A;
        end
      end
      ST_BF_WR_A: begin
        ram_we     = 1'b1;
        state_next = ST_BF_WR_B;
      end
      ST_BF_WR_B: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_b[ADDR_W-1:0];
        ram_wdata  = diff;
        mm_req     = '{start: 1'b1, a: w, b: step};
        state_next = ST_BF_WWAIT;
      end
      ST_BF_WWAIT: begin
        if (mm_done) begin
          if ((bi + CNT_W'(1)) == k && (bj + (k << 1)) == n) begin
            state_next = ST_STAGE;
          end else begin
            state_next = ST_BF_RD_A;
          end
        end
      end
      ST_SC_RD: begin
        ram_raddr = bi[ADDR_W-1:0];
        if (bi == n) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_SC_MUL;
        end
      end
      ST_SC_MUL: begin
        mm_req     = '{start: 1'b1, a: ram_rdata, b: scale};
        state_next = ST_SC_MWAIT;
      end
      ST_SC_MWAIT: begin
        if (mm_done) begin
          state_next = ST_SC_WR;
        end
      end
      ST_SC_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = bi[ADDR_W-1:0];
        ram_wdata  = mm_result;
        state_next = ST_SC_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers: counters, operands, power loop and result
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rv    <= '0;
        st    <= 1'b0;
        bi    <= '0;
        stage <= '0;
        if (in_xfer && (op_t'(s_axis_tuser) == OP_LOAD || op_t'(s_axis_tuser) == OP_READ)) begin
          st <= !in_range;
        end
      end
      ST_RD_WAIT: rv <= ram_rdata;
      ST_RESP:    ;
      ST_BR_CHECK: begin
        if (bi != n && !(bi[ADDR_W-1:0] < rev)) begin
          bi <= bi + CNT_W'(1);
        end
      end
      ST_BR_RD_B: x <= ram_rdata;
      ST_BR_WR_A: ;
      ST_BR_WR_B: bi <= bi + CNT_W'(1);
      ST_STAGE: begin
        pacc <= DATA_W'(1);
        bi   <= '0;
        bj   <= '0;
        if ({1'b0, stage} != {1'b0, lsat}) begin
          pow_scale <= 1'b0;
          pbase     <= inverse_mode ? ROOT_INV : ROOT_FWD;
          pexp      <= (MODP - DATA_W'(1)) >> (stage + 4'd1);
        end else begin
          pow_scale <= 1'b1;
          pbase     <= {{(DATA_W-CNT_W){1'b0}}, n};
          pexp      <= MODP - DATA_W'(2);
        end
      end
      ST_PW_TEST: begin
        if (pexp == '0) begin
          if (pow_scale) begin
            scale <= pacc;
          end else begin
            step <= pacc;
            w    <= DATA_W'(1);
          end
        end
      end
      ST_PW_ACC: begin
        if (mm_done) begin
          pacc <= mm_result;
        end
      end
      ST_PW_SQ: begin
        if (mm_done) begin
          pbase <= mm_result;
          pexp  <= pexp >> 1;
        end
      end
      ST_BF_RD_A:  ;
      ST_BF_RD_B:  x <= ram_rdata;
      ST_BF_MUL:   ;
      ST_BF_MWAIT: begin
        if (mm_done) begin
          y <= mm_result;
        end
      end
      ST_BF_WR_A:  ;
      ST_BF_WR_B:  ;
      ST_BF_WWAIT: begin
        if (mm_done) begin
          if ((bi + CNT_W'(1)) == k) begin
            bi <= '0;
            w  <= DATA_W'(1);
            if ((bj + (k << 1)) == n) begin
              stage <= stage + 4'd1;
            end else begin
              bj <= bj + (k << 1);
            end
          end else begin
            bi <= bi + CNT_W'(1);
            w  <= mm_result;
          end
        end
      end
      ST_SC_RD:    ;
      ST_SC_MUL:   ;
      ST_SC_MWAIT: ;
      ST_SC_WR:    bi <= bi + CNT_W'(1);
      default:     ;
    endcase
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_RESP && out_free) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      out_value    <= rv;
      m_axis_tuser <= st;
    end
  end

endmodule
